/* hdl/lrsf_pkg.sv */
// lrsf_pkg: widths, types, arctangent table and ring constants for the
// lidar ring select filter. Used by every file in hdl/; depends on nothing.
`default_nettype none

package lrsf_pkg;

  // point coordinates and cordic sizing
  localparam int COORD_WIDTH   = 20;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 8;
  localparam int DATA_W        = COORD_WIDTH + GUARD_BITS + 4;
  localparam int ANG_W         = 25;
  localparam int STAGE_IDX_W   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int ATAN_ENTRIES  = 32;

  // cordic gain in q16, applied to the height so both legs carry the gain
  localparam int GAIN_W        = 17;
  localparam int GAIN_FRAC     = 16;
  localparam logic [GAIN_W-1:0] GAIN_Q16 = GAIN_W'(107922);

  // ring mapping, angles in 1/65536 degree
  localparam int RING_W        = 4;
  localparam int MASK_W        = 16;
  localparam int DEG_Q         = 65536;
  localparam int RING_SHIFT    = $clog2(2 * DEG_Q);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DATA_W-1:0]      data_t;
  typedef logic signed [ANG_W-1:0]       ang_t;
  typedef logic [RING_W-1:0]             ring_t;
  typedef logic [MASK_W-1:0]             mask_t;

  localparam ang_t KEEP_LO     = ang_t'(-18 * DEG_Q);
  localparam ang_t KEEP_HI     = ang_t'(16 * DEG_Q);
  localparam ang_t RING0_LIMIT = ang_t'(-14 * DEG_Q);
  localparam logic signed [ANG_W:0] RING_OFFSET = (ANG_W+1)'(16 * DEG_Q);

  // round(atan(2^-i) * 180/pi * 65536)
  localparam ang_t ATAN_TABLE [ATAN_ENTRIES] = '{
    ang_t'(2949120), ang_t'(1740967), ang_t'(919879), ang_t'(466945),
    ang_t'(234379),  ang_t'(117304),  ang_t'(58666),  ang_t'(29335),
    ang_t'(14668),   ang_t'(7334),    ang_t'(3667),   ang_t'(1833),
    ang_t'(917),     ang_t'(458),     ang_t'(229),    ang_t'(115),
    ang_t'(57),      ang_t'(29),      ang_t'(14),     ang_t'(7),
    ang_t'(4),       ang_t'(2),       ang_t'(1),      ang_t'(0),
    ang_t'(0),       ang_t'(0),       ang_t'(0),      ang_t'(0),
    ang_t'(0),       ang_t'(0),       ang_t'(0),      ang_t'(0)
  };

  // state travelling down the cell row
  typedef struct packed {
    logic   valid;
    data_t  cx;
    data_t  cy;
    ang_t   ang;
    data_t  hz;
    coord_t px;
    coord_t py;
    coord_t pz;
  } cell_t;

  // kept point with its ring
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t z;
    ring_t  ring;
  } kept_t;

endpackage

`default_nettype wire

/* hdl/lrsf_channels.sv */
// lrsf_point_if and lrsf_kept_if: valid/ready channels for input points and
// kept points. Depends on lrsf_pkg.
`default_nettype none

interface lrsf_point_if;
  logic                 valid;
  logic                 ready;
  lrsf_pkg::coord_t     point_x_mm;
  lrsf_pkg::coord_t     point_y_mm;
  lrsf_pkg::coord_t     point_z_mm;
  logic                 point_valid;

  modport source (output valid, output point_x_mm, output point_y_mm,
                  output point_z_mm, output point_valid, input ready);
  modport sink   (input valid, input point_x_mm, input point_y_mm,
                  input point_z_mm, input point_valid, output ready);
endinterface

interface lrsf_kept_if;
  logic                 valid;
  logic                 ready;
  lrsf_pkg::coord_t     kept_x_mm;
  lrsf_pkg::coord_t     kept_y_mm;
  lrsf_pkg::coord_t     kept_z_mm;
  lrsf_pkg::ring_t      ring_index;

  modport source (output valid, output kept_x_mm, output kept_y_mm,
                  output kept_z_mm, output ring_index, input ready);
  modport sink   (input valid, input kept_x_mm, input kept_y_mm,
                  input kept_z_mm, input ring_index, output ready);
endinterface

`default_nettype wire

/* hdl/lrsf_front.sv */
// lrsf_front: first pipeline stage, takes magnitudes, adds guard bits and
// scales the height by the cordic gain. Depends on lrsf_pkg.
`default_nettype none

module lrsf_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire lrsf_pkg::coord_t in_x,
  input  wire lrsf_pkg::coord_t in_y,
  input  wire lrsf_pkg::coord_t in_z,
  output lrsf_pkg::cell_t       cell_out
);

  logic signed [lrsf_pkg::COORD_WIDTH:0] xs;
  logic signed [lrsf_pkg::COORD_WIDTH:0] zs;
  logic [lrsf_pkg::COORD_WIDTH:0] xabs;
  logic [lrsf_pkg::COORD_WIDTH:0] zabs;
  logic [lrsf_pkg::COORD_WIDTH+lrsf_pkg::GAIN_W:0] hprod;
  lrsf_pkg::cell_t cell_next;

  // magnitudes and gain-scaled height
  always_comb begin
    xs    = {in_x[lrsf_pkg::COORD_WIDTH-1], in_x};
    zs    = {in_z[lrsf_pkg::COORD_WIDTH-1], in_z};
    xabs  = xs[lrsf_pkg::COORD_WIDTH] ? unsigned'(-xs) : unsigned'(xs);
    zabs  = zs[lrsf_pkg::COORD_WIDTH] ? unsigned'(-zs) : unsigned'(zs);
    hprod = (lrsf_pkg::COORD_WIDTH+lrsf_pkg::GAIN_W+1)'(zabs) *
            (lrsf_pkg::COORD_WIDTH+lrsf_pkg::GAIN_W+1)'(lrsf_pkg::GAIN_Q16);

    cell_next.valid = in_valid;
    cell_next.cx    = lrsf_pkg::data_t'(xabs) <<< lrsf_pkg::GUARD_BITS;
    cell_next.cy    = lrsf_pkg::data_t'(in_y) <<< lrsf_pkg::GUARD_BITS;
    cell_next.ang   = '0;
    cell_next.hz    = lrsf_pkg::data_t'(hprod >> (lrsf_pkg::GAIN_FRAC - lrsf_pkg::GUARD_BITS));
    cell_next.px    = in_x;
    cell_next.py    = in_y;
    cell_next.pz    = in_z;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out.cx  <= cell_next.cx;
      cell_out.cy  <= cell_next.cy;
      cell_out.ang <= cell_next.ang;
      cell_out.hz  <= cell_next.hz;
      cell_out.px  <= cell_next.px;
      cell_out.py  <= cell_next.py;
      cell_out.pz  <= cell_next.pz;
    end
  end

endmodule

`default_nettype wire

/* hdl/lrsf_cordic_cell.sv */
// lrsf_cordic_cell: one registered vectoring cordic iteration; the point and
// the scaled height ride along. Depends on lrsf_pkg.
`default_nettype none

module lrsf_cordic_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic [lrsf_pkg::STAGE_IDX_W-1:0]  shift,
  input  wire lrsf_pkg::ang_t                    atan_step,
  input  wire lrsf_pkg::cell_t                   cell_in,
  output lrsf_pkg::cell_t                        cell_out
);

  lrsf_pkg::data_t xs;
  lrsf_pkg::data_t ys;
  lrsf_pkg::cell_t cell_next;

  // rotate toward y = 0, floor shifts
  always_comb begin
    xs        = cell_in.cx >>> shift;
    ys        = cell_in.cy >>> shift;
    cell_next = cell_in;
    if (!cell_in.cy[lrsf_pkg::DATA_W-1]) begin
      cell_next.cx  = cell_in.cx + ys;
      cell_next.cy  = cell_in.cy - xs;
      cell_next.ang = cell_in.ang + atan_step;
    end else begin
      cell_next.cx  = cell_in.cx - ys;
      cell_next.cy  = cell_in.cy + xs;
      cell_next.ang = cell_in.ang - atan_step;
    end
  end

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_out.cx  <= cell_next.cx;
      cell_out.cy  <= cell_next.cy;
      cell_out.ang <= cell_next.ang;
      cell_out.hz  <= cell_next.hz;
      cell_out.px  <= cell_next.px;
      cell_out.py  <= cell_next.py;
      cell_out.pz  <= cell_next.pz;
    end
  end

endmodule

`default_nettype wire

/* hdl/lrsf_ring_sel.sv */
// lrsf_ring_sel: turns the cordic angle into a signed elevation, maps it to
// a ring and applies the keep mask. Depends on lrsf_pkg.
`default_nettype none

module lrsf_ring_sel (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire lrsf_pkg::mask_t mask,
  input  wire lrsf_pkg::cell_t cell_in,
  output lrsf_pkg::kept_t      kept_out
);

  lrsf_pkg::ang_t               deg;
  logic signed [lrsf_pkg::ANG_W:0] shifted;
  lrsf_pkg::ring_t              ring;
  logic                         in_band;
  lrsf_pkg::kept_t              kept_next;

  // elevation takes the sign opposite to z, ring from elevation
  always_comb begin
    if (cell_in.pz == '0) begin
      deg = '0;
    end else if (!cell_in.pz[lrsf_pkg::COORD_WIDTH-1]) begin
      deg = -cell_in.ang;
    end else begin
      deg = cell_in.ang;
    end
    in_band = (deg > lrsf_pkg::KEEP_LO) && (deg < lrsf_pkg::KEEP_HI);
    shifted = {deg[lrsf_pkg::ANG_W-1], deg} + lrsf_pkg::RING_OFFSET;
    if (deg < lrsf_pkg::RING0_LIMIT) begin
      ring = '0;
    end else begin
      ring = shifted[lrsf_pkg::RING_SHIFT +: lrsf_pkg::RING_W];
    end

    kept_next.valid = cell_in.valid && in_band && mask[ring];
    kept_next.x     = cell_in.px;
    kept_next.y     = cell_in.py;
    kept_next.z     = cell_in.pz;
    kept_next.ring  = ring;
  end

  // decision register
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_out.valid <= 1'b0;
    end else if (en) begin
      kept_out.valid <= kept_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kept_out.x    <= kept_next.x;
      kept_out.y    <= kept_next.y;
      kept_out.z    <= kept_next.z;
      kept_out.ring <= kept_next.ring;
    end
  end

endmodule

`default_nettype wire

/* hdl/lidar_ring_select_filter.sv */
// Lidar ring select filter: one point per clock in, kept points with their
// 16-line ring index out. An accepted beat passes through one magnitude and
// gain stage, a row of CORDIC_STAGES cells that finds the horizontal range,
// a second row that finds the elevation angle, one ring and mask stage and
// the output register. The cell rows are fully pipelined, so a new point is
// taken every clock; a two-entry output register and skid stage absorb a
// stalled sink, and the input is held off only once both are full. Points
// with point_valid low, an elevation outside the keep band or a cleared
// mask bit produce no beat.
// ring_keep_mask resets to all ones and is written with cfg_we/cfg_wdata.
// Depends on lrsf_pkg, lrsf_channels, lrsf_front, lrsf_cordic_cell and
// lrsf_ring_sel.
`default_nettype none

module lidar_ring_select_filter (
  input  wire logic            clk,
  input  wire logic            rst,
  lrsf_point_if.sink           points,
  lrsf_kept_if.source          kept,
  input  wire logic            cfg_we,
  input  wire lrsf_pkg::mask_t cfg_wdata
);

  lrsf_pkg::mask_t ring_keep_mask;
  logic            en;
  lrsf_pkg::cell_t row1 [lrsf_pkg::CORDIC_STAGES+1];
  lrsf_pkg::cell_t row2 [lrsf_pkg::CORDIC_STAGES+1];
  lrsf_pkg::kept_t decided;
  lrsf_pkg::kept_t out_reg;
  lrsf_pkg::kept_t skid;
  logic            out_free;
  logic            pipe_take;

  // mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_keep_mask <= '1;
    end else if (cfg_we) begin
      ring_keep_mask <= cfg_wdata;
    end
  end

  // pipeline moves whenever the skid stage is empty
  assign en           = !skid.valid;
  assign points.ready = en;

  lrsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (points.valid && points.point_valid),
    .in_x     (points.point_x_mm),
    .in_y     (points.point_y_mm),
    .in_z     (points.point_z_mm),
    .cell_out (row1[0])
  );

  // range row: vectoring on (|x|, y)
  for (genvar i = 0; i < lrsf_pkg::CORDIC_STAGES; i++) begin : g_row1
    lrsf_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift     (lrsf_pkg::STAGE_IDX_W'(i)),
      .atan_step (lrsf_pkg::ATAN_TABLE[i]),
      .cell_in   (row1[i]),
      .cell_out  (row1[i+1])
    );
  end

  // hand over: range and scaled height start the angle row
  always_comb begin
    row2[0]     = row1[lrsf_pkg::CORDIC_STAGES];
    row2[0].cy  = row1[lrsf_pkg::CORDIC_STAGES].hz;
    row2[0].ang = '0;
  end

  // angle row: vectoring on (range, |z|)
  for (genvar i = 0; i < lrsf_pkg::CORDIC_STAGES; i++) begin : g_row2
    lrsf_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .shift     (lrsf_pkg::STAGE_IDX_W'(i)),
      .atan_step (lrsf_pkg::ATAN_TABLE[i]),
      .cell_in   (row2[i]),
      .cell_out  (row2[i+1])
    );
  end

  lrsf_ring_sel u_ring_sel (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .mask     (ring_keep_mask),
    .cell_in  (row2[lrsf_pkg::CORDIC_STAGES]),
    .kept_out (decided)
  );

  // output register and skid stage
  assign out_free  = !out_reg.valid || kept.ready;
  assign pipe_take = en && decided.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
      skid.valid    <= 1'b0;
    end else if (skid.valid) begin
      if (out_free) begin
        out_reg.valid <= 1'b1;
        skid.valid    <= 1'b0;
      end
    end else if (pipe_take) begin
      if (out_free) begin
        out_reg.valid <= 1'b1;
      end else begin
        skid.valid <= 1'b1;
      end
    end else if (out_free) begin
      out_reg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid.valid) begin
      if (out_free) begin
        out_reg.x    <= skid.x;
        out_reg.y    <= skid.y;
        out_reg.z    <= skid.z;
        out_reg.ring <= skid.ring;
      end
    end else if (pipe_take) begin
      if (out_free) begin
        out_reg.x    <= decided.x;
        out_reg.y    <= decided.y;
        out_reg.z    <= decided.z;
        out_reg.ring <= decided.ring;
      end else begin
        skid.x    <= decided.x;
        skid.y    <= decided.y;
        skid.z    <= decided.z;
        skid.ring <= decided.ring;
      end
    end
  end

  // output beat
  assign kept.valid      = out_reg.valid;
  assign kept.kept_x_mm  = out_reg.x;
  assign kept.kept_y_mm  = out_reg.y;
  assign kept.kept_z_mm  = out_reg.z;
  assign kept.ring_index = out_reg.ring;

endmodule

`default_nettype wire
